@@ hw/rtl/msw_pkg.sv @@
// Shared types and constants for the minute:second stopwatch.
`default_nettype none

package msw_pkg;

    // Event codes carried by one input word
    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_PAUSE = 3'd2,
        ACT_RESET = 3'd3,
        ACT_END   = 3'd4
    } t_action;

    // Countdown length after reset
    localparam logic [2:0] END_HOLD_RESET = 3'd3;

    // Highest digit values for the 00..59 BCD counters
    localparam logic [3:0] UNITS_MAX = 4'd9;
    localparam logic [2:0] TENS_MAX  = 3'd5;

    // One BCD time field: tens in 0..5, units in 0..9
    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] units;
    } t_bcd60;

endpackage

`default_nettype wire

@@ hw/rtl/minute_second_stopwatch.sv @@
// Minute:second stopwatch with end-button hold countdown, packed BCD display.
// A result word passes from the input register into the result register once the
// result stage is free or draining. Throughput: one word per cycle while the output
// is not stalled; the time counters and countdown update in one pass.
// Reset (synchronous, active low) clears time, stops the count, disarms the
// countdown and loads end_hold_ticks with 3.
`default_nettype none

module minute_second_stopwatch (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write channel
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_data,
    // Event input channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_action,
    input  wire logic       i_end_pressed,
    // Result channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_display_valid,
    output logic [6:0]      o_seconds_bcd,
    output logic [6:0]      o_minutes_bcd,
    output logic            o_done_res
);

    // Configuration register
    logic [2:0] r_end_hold_ticks;

    // Input stage
    logic       r_in_valid;
    logic [2:0] r_action;
    logic       r_pressed;

    // Stopwatch state
    msw_pkg::t_bcd60 r_sec, n_sec;
    msw_pkg::t_bcd60 r_min, n_min;
    logic            r_running, n_running;
    logic            r_end_armed, n_end_armed;
    logic [2:0]      r_end_remaining, n_end_remaining;

    // Result stage
    logic       r_out_valid;
    logic       r_display_valid, n_display_valid;
    logic [6:0] r_seconds_bcd, n_seconds_bcd;
    logic [6:0] r_minutes_bcd, n_minutes_bcd;
    logic       r_done_res, n_done_res;

    logic w_move;
    logic w_blank;

    // Input word moves into the result stage when that stage is free or draining
    assign w_move      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_move;
    assign o_cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_hold_ticks <= msw_pkg::END_HOLD_RESET;
        end else if (i_cfg_valid) begin
            r_end_hold_ticks <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action  <= i_action;
            r_pressed <= i_end_pressed;
        end
    end

    // Event decode and state update
    always_comb begin
        n_sec           = r_sec;
        n_min           = r_min;
        n_running       = r_running;
        n_end_armed     = r_end_armed;
        n_end_remaining = r_end_remaining;
        n_display_valid = 1'b0;
        n_done_res      = 1'b0;
        w_blank         = 1'b0;

        unique case (r_action)
            msw_pkg::ACT_TICK: begin
                if (r_end_armed && r_end_remaining == 3'd0) begin
                    // Countdown expired: stop, blank, flag done
                    n_done_res      = 1'b1;
                    w_blank         = 1'b1;
                    n_display_valid = 1'b1;
                    n_running       = 1'b0;
                    n_end_armed     = 1'b0;
                end else begin
                    if (r_end_armed) begin
                        n_end_remaining = r_end_remaining - 3'd1;
                    end
                    if (r_running) begin
                        n_display_valid = 1'b1;
                        // Seconds then minutes, each 00..59 in BCD
                        if (r_sec.units != msw_pkg::UNITS_MAX) begin
                            n_sec.units = r_sec.units + 4'd1;
                        end else begin
                            n_sec.units = 4'd0;
                            if (r_sec.tens != msw_pkg::TENS_MAX) begin
                                n_sec.tens = r_sec.tens + 3'd1;
                            end else begin
                                n_sec.tens = 3'd0;
                                if (r_min.units != msw_pkg::UNITS_MAX) begin
                                    n_min.units = r_min.units + 4'd1;
                                end else begin
                                    n_min.units = 4'd0;
                                    if (r_min.tens != msw_pkg::TENS_MAX) begin
                                        n_min.tens = r_min.tens + 3'd1;
                                    end else begin
                                        n_min.tens = 3'd0;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            msw_pkg::ACT_START: begin
                if (!r_running) begin
                    n_running       = 1'b1;
                    n_display_valid = 1'b1;
                end
            end
            msw_pkg::ACT_PAUSE: begin
                n_running = 1'b0;
            end
            msw_pkg::ACT_RESET: begin
                n_sec           = '0;
                n_min           = '0;
                n_running       = 1'b0;
                n_display_valid = 1'b1;
            end
            msw_pkg::ACT_END: begin
                if (r_pressed) begin
                    n_end_armed     = 1'b1;
                    n_end_remaining = r_end_hold_ticks;
                end else begin
                    n_end_armed     = 1'b0;
                    n_end_remaining = 3'd0;
                end
            end
            default: begin
                // unused codes: no effect
            end
        endcase

        // Digits shown only when written and not blanked
        if (n_display_valid && !w_blank) begin
            n_seconds_bcd = n_sec;
            n_minutes_bcd = n_min;
        end else begin
            n_seconds_bcd = 7'd0;
            n_minutes_bcd = 7'd0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec           <= '0;
            r_min           <= '0;
            r_running       <= 1'b0;
            r_end_armed     <= 1'b0;
            r_end_remaining <= 3'd0;
        end else if (w_move) begin
            r_sec           <= n_sec;
            r_min           <= n_min;
            r_running       <= n_running;
            r_end_armed     <= n_end_armed;
            r_end_remaining <= n_end_remaining;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_display_valid <= n_display_valid;
            r_seconds_bcd   <= n_seconds_bcd;
            r_minutes_bcd   <= n_minutes_bcd;
            r_done_res      <= n_done_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_display_valid = r_display_valid;
    assign o_seconds_bcd   = r_seconds_bcd;
    assign o_minutes_bcd   = r_minutes_bcd;
    assign o_done_res      = r_done_res;

    // Checks
    a_digits_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec.units <= msw_pkg::UNITS_MAX && r_sec.tens <= msw_pkg::TENS_MAX &&
        r_min.units <= msw_pkg::UNITS_MAX && r_min.tens <= msw_pkg::TENS_MAX)
        else $error("time digit out of BCD range");

    a_done_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done_res) |->
        (r_display_valid && r_seconds_bcd == 7'd0 && r_minutes_bcd == 7'd0))
        else $error("done word not blanked");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && n_done_res) |=> (!r_running && !r_end_armed))
        else $error("count or countdown alive after done");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_display_valid)
        && $stable(r_seconds_bcd) && $stable(r_done_res)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
